// ===== rtl/core/dsm_pkg.sv =====
`default_nettype none
package dsm_pkg;
    localparam int SESSIONS   = 8;
    localparam int DISPLAYS   = 4;
    localparam int OWNER_BITS = 16;

    localparam int SLOT_W = $clog2(SESSIONS);
    localparam int DISP_W = $clog2(DISPLAYS);
    localparam int FMT_W  = 8;

    localparam int SLOT_FIELD_W = 3;
    localparam int DISP_FIELD_W = 2;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_FIELDS_W = 17;

    typedef enum logic [1:0] {
        ACT_CREATE  = 2'd0,
        ACT_ENABLE  = 2'd1,
        ACT_DESTROY = 2'd2,
        ACT_FIND    = 2'd3
    } t_action;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    typedef struct packed {
        logic                  create;
        logic                  find;
        logic [OWNER_BITS-1:0] owner;
        logic [DISP_W-1:0]     disp;
        logic [FMT_W-1:0]      fmt;
        logic                  free;
        logic [SLOT_W-1:0]     free_slot;
    } t_slot_cmd;

    typedef struct packed {
        logic              used;
        logic [DISP_W-1:0] disp;
        logic [FMT_W-1:0]  fmt;
    } t_slot_info;

    typedef struct packed {
        logic              push;
        logic              pull;
        logic [DISP_W-1:0] disp;
        logic [SLOT_W-1:0] slot;
    } t_stack_cmd;
endpackage
`default_nettype wire

// ===== rtl/core/display_session_mru_stack.sv =====
// Session slot table with one most-recently-enabled stack per display. Items
// are create, enable (move to front and request a format write), destroy
// (free the slot, remove it from its stack and close the gap) and find by
// owner id; each gives exactly one result. One item is in work at a time:
// it passes the chain of slot cells (allocation, owner search, slot lookup),
// then the chain of stack cells (search and shift of the addressed display's
// stack), where it waits while the output register holds an untaken result.
// The output register lets the next item be accepted while a result still
// waits. Reset clears the sequencer state, the output valid, the slot used
// flags and the stack valid bits.
`default_nettype none
module display_session_mru_stack (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // owner_id, display_id, display_format, session_slot
    input  logic [dsm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic [dsm_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, result_slot, on_top, format_write, format_display, format_value
    output logic [dsm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import dsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SLOT  = 3'b010,
        S_STACK = 3'b100
    } t_state;

    t_state                  r_state;
    t_action                 r_act;
    logic [OWNER_BITS-1:0]   r_owner;
    logic [DISP_W-1:0]       r_disp;
    logic [FMT_W-1:0]        r_fmt;
    logic [SLOT_FIELD_W-1:0] r_slot;

    logic                    r_ok;
    logic [SLOT_FIELD_W-1:0] r_tslot;
    logic [DISP_W-1:0]       r_tdisp;
    logic [FMT_W-1:0]        r_tfmt;

    logic                    r_ovalid;
    logic [OUT_DATA_W-1:0]   r_odata;

    t_slot_cmd               w_slot_cmd;
    logic [SESSIONS:0]       w_claim;
    logic [SESSIONS-1:0]     w_take;
    t_slot_info              w_info [SESSIONS];
    logic [SLOT_W-1:0]       w_take_idx;
    t_slot_info              w_take_info;
    t_slot_info              w_addr_info;
    logic                    w_addr_ok;

    t_stack_cmd              w_stk_cmd;
    logic [SESSIONS:0]       w_hit;
    t_entry                  w_entry [SESSIONS];
    t_entry                  w_new;
    logic                    w_full;
    logic                    w_top_now;
    logic                    w_go;
    logic                    w_accept;

    logic [1:0]              w_status;
    logic                    w_top;
    logic                    w_fw;
    logic [DISP_FIELD_W-1:0] w_fd;
    logic [FMT_W-1:0]        w_fv;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // slot cell chain
    assign w_slot_cmd.create    = (r_state == S_SLOT) && (r_act == ACT_CREATE);
    assign w_slot_cmd.find      = (r_state == S_SLOT) && (r_act == ACT_FIND);
    assign w_slot_cmd.owner     = r_owner;
    assign w_slot_cmd.disp      = r_disp;
    assign w_slot_cmd.fmt       = r_fmt;
    assign w_slot_cmd.free      = (r_state == S_SLOT) && (r_act == ACT_DESTROY) && w_addr_ok;
    assign w_slot_cmd.free_slot = r_slot[SLOT_W-1:0];

    assign w_claim[0] = 1'b0;

    for (genvar k = 0; k < SESSIONS; k++) begin : g_slot
        dsm_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (SLOT_W'(k)),
            .i_cmd   (w_slot_cmd),
            .i_claim (w_claim[k]),
            .o_claim (w_claim[k+1]),
            .o_take  (w_take[k]),
            .o_info  (w_info[k])
        );
    end

    always_comb begin
        w_take_idx  = '0;
        w_take_info = '0;
        for (int k = 0; k < SESSIONS; k++) begin
            if (w_take[k]) begin
                w_take_idx  = w_take_idx | SLOT_W'(k);
                w_take_info = w_take_info | w_info[k];
            end
        end
    end

    assign w_addr_info = w_info[r_slot[SLOT_W-1:0]];
    assign w_addr_ok   = ({1'b0, r_slot} < (SLOT_FIELD_W+1)'(SESSIONS)) && w_addr_info.used;

    // stack cell chain
    assign w_go = (r_state == S_STACK) && (!r_ovalid || m_axis_tready);

    assign w_stk_cmd.push = w_go && (r_act == ACT_ENABLE) && r_ok && !w_full;
    assign w_stk_cmd.pull = w_go && (r_act == ACT_DESTROY) && r_ok;
    assign w_stk_cmd.disp = r_tdisp;
    assign w_stk_cmd.slot = r_tslot[SLOT_W-1:0];

    assign w_new.valid = 1'b1;
    assign w_new.slot  = r_tslot[SLOT_W-1:0];
    assign w_hit[0]    = 1'b0;

    for (genvar k = 0; k < SESSIONS; k++) begin : g_stack
        t_entry w_prev;
        t_entry w_next;
        if (k == 0) begin : g_head
            assign w_prev = w_new;
        end else begin : g_body
            assign w_prev = w_entry[k-1];
        end
        if (k == SESSIONS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_entry[k+1];
        end
        dsm_stack_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_stk_cmd),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_hit   (w_hit[k]),
            .o_hit   (w_hit[k+1]),
            .o_entry (w_entry[k])
        );
    end

    assign w_full    = w_entry[SESSIONS-1].valid && !w_hit[SESSIONS];
    assign w_top_now = w_entry[0].valid && (w_entry[0].slot == r_tslot[SLOT_W-1:0]);

    always_comb begin
        w_status = STAT_OK;
        w_top    = 1'b0;
        w_fw     = 1'b0;
        w_fd     = '0;
        w_fv     = '0;
        unique case (r_act)
            ACT_CREATE: begin
                w_status = r_ok ? STAT_OK : STAT_FULL;
            end
            ACT_FIND: begin
                w_status = r_ok ? STAT_OK : STAT_MISSING;
                w_top    = r_ok && w_top_now;
            end
            ACT_ENABLE: begin
                if (!r_ok) begin
                    w_status = STAT_MISSING;
                end else if (w_full) begin
                    w_status = STAT_FULL;
                    w_top    = w_top_now;
                end else begin
                    w_top = 1'b1;
                    w_fw  = 1'b1;
                    w_fd  = DISP_FIELD_W'(r_tdisp);
                    w_fv  = r_tfmt;
                end
            end
            ACT_DESTROY: begin
                w_status = r_ok ? STAT_OK : STAT_MISSING;
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_SLOT;
                end
                S_SLOT: begin
                    r_state <= S_STACK;
                end
                S_STACK: begin
                    if (w_go) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= t_action'(s_axis_tuser);
            r_owner <= s_axis_tdata[OWNER_BITS-1:0];
            r_disp  <= s_axis_tdata[16 +: DISP_W];
            r_fmt   <= s_axis_tdata[25:18];
            r_slot  <= s_axis_tdata[28:26];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SLOT) begin
            unique case (r_act)
                ACT_CREATE: begin
                    r_ok    <= w_claim[SESSIONS];
                    r_tslot <= SLOT_FIELD_W'(w_take_idx);
                end
                ACT_FIND: begin
                    r_ok    <= w_claim[SESSIONS];
                    r_tslot <= SLOT_FIELD_W'(w_take_idx);
                    r_tdisp <= w_take_info.disp;
                end
                ACT_ENABLE, ACT_DESTROY: begin
                    r_ok    <= w_addr_ok;
                    r_tslot <= r_slot;
                    r_tdisp <= w_addr_info.disp;
                    r_tfmt  <= w_addr_info.fmt;
                end
                default: begin
                    r_ok <= 1'b0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_go) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_odata <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                        w_fv, w_fd, w_fw, w_top, r_tslot, w_status};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dsm_slot_cell.sv =====
`default_nettype none
module dsm_slot_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [dsm_pkg::SLOT_W-1:0]  i_index,
    input  dsm_pkg::t_slot_cmd          i_cmd,
    input  logic                        i_claim,
    output logic                        o_claim,
    output logic                        o_take,
    output dsm_pkg::t_slot_info         o_info
);
    import dsm_pkg::*;

    logic                  r_used;
    logic [OWNER_BITS-1:0] r_owner;
    logic [DISP_W-1:0]     r_disp;
    logic [FMT_W-1:0]      r_fmt;
    logic                  w_hit;

    // free slot for create, owner match for find
    assign w_hit = (i_cmd.create && !r_used) ||
                   (i_cmd.find && r_used && (r_owner == i_cmd.owner));
    assign o_take  = w_hit && !i_claim;
    assign o_claim = i_claim || w_hit;

    assign o_info.used = r_used;
    assign o_info.disp = r_disp;
    assign o_info.fmt  = r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.create && o_take) begin
            r_used <= 1'b1;
        end else if (i_cmd.free && (i_cmd.free_slot == i_index)) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.create && o_take) begin
            r_owner <= i_cmd.owner;
            r_disp  <= i_cmd.disp;
            r_fmt   <= i_cmd.fmt;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dsm_stack_cell.sv =====
`default_nettype none
module dsm_stack_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dsm_pkg::t_stack_cmd i_cmd,
    input  dsm_pkg::t_entry     i_prev,
    input  dsm_pkg::t_entry     i_next,
    input  logic                i_hit,
    output logic                o_hit,
    output dsm_pkg::t_entry     o_entry
);
    import dsm_pkg::*;

    logic [DISPLAYS-1:0] r_valid;
    logic [SLOT_W-1:0]   r_slot [DISPLAYS];
    logic                w_match;
    logic                w_load;
    t_entry              n_entry;

    assign o_entry.valid = r_valid[i_cmd.disp];
    assign o_entry.slot  = r_slot[i_cmd.disp];

    assign w_match = o_entry.valid && (o_entry.slot == i_cmd.slot);
    assign o_hit   = i_hit || w_match;

    // push shifts down up to the match, pull shifts up from the match
    always_comb begin
        w_load  = 1'b0;
        n_entry = o_entry;
        if (i_cmd.push && !i_hit) begin
            w_load  = 1'b1;
            n_entry = i_prev;
        end else if (i_cmd.pull && o_hit) begin
            w_load  = 1'b1;
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_load) begin
            r_valid[i_cmd.disp] <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_slot[i_cmd.disp] <= n_entry.slot;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dsm_checker.sv =====
`default_nettype none
module dsm_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [dsm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import dsm_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_fw_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[1:0] == STAT_OK)
        else $error("format write on failed item");

    a_fw_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[16:7] == 10'd0)
        else $error("format fields set without format write");

    a_fail_not_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK) |-> !m_axis_tdata[5])
        else $error("failed item reports on top");
endmodule

bind display_session_mru_stack dsm_checker u_dsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== test/session_stack_checker.sv =====
`default_nettype none
module session_stack_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    // owner_id, display_id, display_format, session_slot
    input  logic [dsm_pkg::IN_DATA_W-1:0] i_req_data,
    // action
    input  logic [dsm_pkg::IN_USER_W-1:0] i_req_user,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    // status, result_slot, on_top, format_write, format_display, format_value
    input  logic [dsm_pkg::OUT_DATA_W-1:0] i_rsp_data,
    output int                            o_errors,
    output int                            o_pending
);
    import dsm_pkg::*;

    // listed from the highest bit down
    typedef struct packed {
        logic [FMT_W-1:0] fmt_val;
        logic [1:0]       fmt_disp;
        logic             fmt_wr;
        logic             on_top;
        logic [2:0]       slot;
        logic [1:0]       status;
    } t_session_result;

    logic                  slot_used [SESSIONS];
    logic [OWNER_BITS-1:0] slot_owner [SESSIONS];
    logic [DISP_W-1:0]     slot_disp [SESSIONS];
    logic [FMT_W-1:0]      slot_fmt [SESSIONS];
    t_entry                stack_mem [DISPLAYS][SESSIONS];

    t_session_result expected_results [$];

    function automatic bit slot_on_top(input logic [SLOT_W-1:0] s);
        t_entry head;
        if (!slot_used[s]) return 1'b0;
        head = stack_mem[slot_disp[s]][0];
        return head.valid && head.slot == s;
    endfunction

    function automatic int stack_pos(input logic [DISP_W-1:0] d, input logic [SLOT_W-1:0] s);
        for (int i = 0; i < SESSIONS; i++) begin
            if (stack_mem[d][i].valid && stack_mem[d][i].slot == s) return i;
        end
        return -1;
    endfunction

    task automatic apply_session_op(
        input  t_action               act,
        input  logic [OWNER_BITS-1:0] owner,
        input  logic [DISP_W-1:0]     disp,
        input  logic [FMT_W-1:0]      fmt,
        input  logic [SLOT_W-1:0]     slot,
        output t_session_result       r
    );
        int pos;
        int k;
        bit done;
        logic [DISP_W-1:0] d;
        r = '0;
        done = 1'b0;
        case (act)
            ACT_CREATE: begin
                r.status = STAT_FULL;
                for (int i = 0; i < SESSIONS; i++) begin
                    if (!done && !slot_used[i]) begin
                        done = 1'b1;
                        slot_used[i] = 1'b1;
                        slot_owner[i] = owner;
                        slot_disp[i] = disp;
                        slot_fmt[i] = fmt;
                        r.status = STAT_OK;
                        r.slot = i[2:0];
                        r.on_top = slot_on_top(i[SLOT_W-1:0]);
                    end
                end
            end
            ACT_FIND: begin
                r.status = STAT_MISSING;
                for (int i = 0; i < SESSIONS; i++) begin
                    if (!done && slot_used[i] && slot_owner[i] == owner) begin
                        done = 1'b1;
                        r.status = STAT_OK;
                        r.slot = i[2:0];
                        r.on_top = slot_on_top(i[SLOT_W-1:0]);
                    end
                end
            end
            default: begin
                r.slot = slot;
                if (!slot_used[slot]) begin
                    r.status = STAT_MISSING;
                end else begin
                    d = slot_disp[slot];
                    pos = stack_pos(d, slot);
                    if (act == ACT_ENABLE) begin
                        if (pos < 0 && stack_mem[d][SESSIONS-1].valid) begin
                            r.status = STAT_FULL;
                            r.on_top = slot_on_top(slot);
                        end else begin
                            k = (pos < 0) ? SESSIONS - 1 : pos;
                            for (; k > 0; k--) stack_mem[d][k] = stack_mem[d][k-1];
                            stack_mem[d][0] = '{valid: 1'b1, slot: slot};
                            r.fmt_wr = 1'b1;
                            r.fmt_disp = d;
                            r.fmt_val = slot_fmt[slot];
                            r.on_top = 1'b1;
                        end
                    end else begin
                        if (pos >= 0) begin
                            for (k = pos; k < SESSIONS - 1; k++) begin
                                stack_mem[d][k] = stack_mem[d][k+1];
                            end
                            stack_mem[d][SESSIONS-1] = '0;
                        end
                        slot_used[slot] = 1'b0;
                        slot_owner[slot] = '0;
                        slot_disp[slot] = '0;
                        slot_fmt[slot] = '0;
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_session_result r;
        t_session_result got;
        if (!i_rst_n) begin
            o_errors = 0;
            expected_results.delete();
            for (int i = 0; i < SESSIONS; i++) begin
                slot_used[i] = 1'b0;
                slot_owner[i] = '0;
                slot_disp[i] = '0;
                slot_fmt[i] = '0;
                for (int j = 0; j < DISPLAYS; j++) stack_mem[j][i] = '0;
            end
        end else begin
            if (i_req_valid && i_req_ready) begin
                apply_session_op(t_action'(i_req_user), i_req_data[15:0], i_req_data[17:16],
                                 i_req_data[25:18], i_req_data[28:26], r);
                expected_results.push_back(r);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[16:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, got);
                    o_errors++;
                end else begin
                    r = expected_results.pop_front();
                    check_field("status", r.status, got.status);
                    check_field("result_slot", r.slot, got.slot);
                    check_field("on_top", r.on_top, got.on_top);
                    check_field("format_write", r.fmt_wr, got.fmt_wr);
                    check_field("format_display", r.fmt_disp, got.fmt_disp);
                    check_field("format_value", r.fmt_val, got.fmt_val);
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule
`default_nettype wire

// ===== test/display_session_mru_stack_tb.sv =====
`default_nettype none
module display_session_mru_stack_tb;
    import dsm_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_ITEMS   = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // owner_id, display_id, display_format, session_slot
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // action
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // status, result_slot, on_top, format_write, format_display, format_value
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int  errors;
    int  pending;
    bit  rx_calm;
    logic [15:0] owner_pool [6];

    display_session_mru_stack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    session_stack_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #(8 * 1000000);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(input t_action act, input logic [15:0] owner,
                                input logic [1:0] disp, input logic [7:0] fmt,
                                input logic [2:0] slot);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, slot, fmt, disp, owner};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    initial begin
        m_axis_tready = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!rx_calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_action act;
        logic [15:0] owner;
        int pick;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_CREATE;
        rx_calm       = 1'b0;
        for (int i = 0; i < 6; i++) owner_pool[i] = 16'($urandom);
        owner_pool[0] = 16'h0000;
        owner_pool[1] = 16'hffff;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty table
        send_request(ACT_FIND,    16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_DESTROY, 16'hffff, 2'd3, 8'hff, 3'd7);
        // fill the table, duplicate owner included
        send_request(ACT_CREATE,  16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_CREATE,  16'hffff, 2'd3, 8'hff, 3'd7);
        send_request(ACT_CREATE,  16'h1234, 2'd0, 8'h5a, 3'd0);
        send_request(ACT_CREATE,  16'h1234, 2'd0, 8'ha5, 3'd0);
        send_request(ACT_CREATE,  16'h0004, 2'd1, 8'h11, 3'd0);
        send_request(ACT_CREATE,  16'h0005, 2'd2, 8'h22, 3'd0);
        send_request(ACT_CREATE,  16'h0006, 2'd0, 8'h33, 3'd0);
        send_request(ACT_CREATE,  16'h0007, 2'd0, 8'h44, 3'd0);
        send_request(ACT_CREATE,  16'h0008, 2'd1, 8'h55, 3'd0);
        // stack moves
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd2);
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd3);
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd1);
        send_request(ACT_FIND,    16'h1234, 2'd0, 8'h00, 3'd0);
        send_request(ACT_DESTROY, 16'h0000, 2'd0, 8'h00, 3'd2);
        send_request(ACT_DESTROY, 16'h0000, 2'd0, 8'h00, 3'd5);
        send_request(ACT_FIND,    16'hffff, 2'd0, 8'h00, 3'd0);
        send_request(ACT_ENABLE,  16'h0000, 2'd0, 8'h00, 3'd7);
        send_request(ACT_DESTROY, 16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_FIND,    16'h0000, 2'd0, 8'h00, 3'd0);
        send_request(ACT_CREATE,  16'h0009, 2'd2, 8'h81, 3'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) rx_calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30)      act = ACT_CREATE;
            else if (pick < 65) act = ACT_ENABLE;
            else if (pick < 85) act = ACT_DESTROY;
            else                act = ACT_FIND;
            owner = ($urandom_range(0, 3) == 0) ? 16'($urandom) : owner_pool[$urandom_range(0, 5)];
            send_request(act, owner, 2'($urandom), 8'($urandom), 3'($urandom));
            if (!rx_calm && $urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 9));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/dsm_pkg.sv
rtl/core/dsm_slot_cell.sv
rtl/core/dsm_stack_cell.sv
rtl/core/display_session_mru_stack.sv
rtl/core/dsm_checker.sv
test/session_stack_checker.sv
test/display_session_mru_stack_tb.sv
